### hdl/sse_pkg.sv
`default_nettype none
package sse_pkg;

   localparam int ANG_W     = 38;
   localparam int CX_W      = 50;
   localparam int MUL_W     = 36;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int CSR_IDX_W = 4;
   localparam int ATAN_N    = 30;

   localparam logic [CSR_IDX_W-1:0] CSR_THETA_MAX = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_MIN     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_MAX     = 4'd3;

   localparam logic signed [ANG_W-1:0] PI_Q30      = 38'sd3373259426;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 38'sd6746518853;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 38'sd1686629713;
   localparam logic signed [CX_W-1:0]  GAIN_Q30    = 50'sd652032874;

   typedef struct packed {
      logic [16:0] u_coord;
      logic [16:0] v_coord;
      logic        want_derivatives;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] dpdu_x;
      logic signed [31:0] dpdu_y;
      logic signed [31:0] dpdu_z;
      logic signed [31:0] dpdv_x;
      logic signed [31:0] dpdv_y;
      logic signed [31:0] dpdv_z;
   } rsp_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         5'd24: v = 30'd64;
         5'd25: v = 30'd32;
         5'd26: v = 30'd16;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### hdl/sphere_surface_eval_unit.sv
// The theta and alpha angles are each wrapped into range by 2*pi steps before their rotation.
// After any register write the first item also runs two arcsines, each with a bit-serial
// square root, operand normalization and a CORDIC vectoring pass before the evaluation.
// The block takes one item at a time; a stalled result holds the sequencer.
// One shared CORDIC stage and one multiplier do all the work.
// Reset: synchronous, active high; registers take their defaults, angle cache invalid.
`default_nettype none
module sphere_surface_eval_unit
   import sse_pkg::*;
#(
   parameter int CORDIC_STEPS = 18
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  req_type                     req_payload,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output rsp_type                     rsp_payload,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [CSR_IDX_W-1:0]        csr_index,
   input  wire  [31:0]                 csr_data
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_AS_RR, S_AS_ZZ, S_AS_SUB, S_AS_SQRT, S_AS_NORM, S_AS_COR, S_AS_DONE,
      S_TH_MUL, S_TH_RND, S_AL_MUL, S_AL_RND, S_WRAP, S_ROT, S_ROT_DONE,
      S_M_RC, S_M_RS, S_M_PX, S_M_PY, S_M_A, S_M_B, S_M_C, S_M_D, S_M_E, S_M_F,
      S_M_G, S_M_H, S_OUT
   } state_type;

   state_type state_ff;

   logic [18:0]              theta_max_ff;
   logic [30:0]              radius_ff;
   logic signed [31:0]       z_min_ff;
   logic signed [31:0]       z_max_ff;
   logic signed [19:0]       alpha_low_ff;
   logic signed [19:0]       alpha_span_ff;
   logic                     cached_ff;

   logic [16:0]              u_ff;
   logic [16:0]              v_ff;
   logic                     deriv_ff;
   logic                     side_ff;
   logic                     pass_ff;
   logic                     neg_ff;

   logic [61:0]              sq_ff;
   logic [61:0]              n_ff;
   logic [62:0]              res_ff;
   logic [62:0]              bit_ff;

   logic signed [CX_W-1:0]   cx_ff;
   logic signed [CX_W-1:0]   cy_ff;
   logic signed [ANG_W-1:0]  cz_ff;
   logic [STEP_W-1:0]        iter_ff;
   logic signed [ANG_W-1:0]  angle_ff;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [MUL_W-1:0]  ct_ff, st_ff, ca_ff, sa_ff;
   logic signed [MUL_W-1:0]  rc_ff, rs_ff, px_ff, py_ff, t1_ff, t2_ff;
   logic signed [31:0]       dux_ff, duy_ff, dvx_ff, dvy_ff, dvz_ff;

   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] s;
      if (v > PROD_W'(64'sd2147483647)) begin
         s = 32'sh7FFFFFFF;
      end else if (v < -PROD_W'(64'sd2147483648)) begin
         s = 32'sh80000000;
      end else begin
         s = v[31:0];
      end
      return s;
   endfunction

   // clamp selected z limit to [-r, r]
   logic signed [32:0] r_s;
   logic signed [32:0] z_sel;
   logic signed [31:0] zc;
   always_comb begin
      r_s   = signed'({2'b00, radius_ff});
      z_sel = side_ff ? 33'(z_max_ff) : 33'(z_min_ff);
      if (z_sel > r_s) begin
         zc = r_s[31:0];
      end else if (z_sel < -r_s) begin
         zc = -r_s[31:0];
      end else begin
         zc = z_sel[31:0];
      end
   end

   // shared multiplier, operands chosen by sequencer
   logic signed [MUL_W-1:0] mul_a, mul_b;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_AS_RR:  begin mul_a = MUL_W'(r_s);  mul_b = MUL_W'(r_s); end
         S_AS_ZZ:  begin mul_a = MUL_W'(zc);   mul_b = MUL_W'(zc); end
         S_TH_MUL: begin
            mul_a = signed'(MUL_W'(u_ff));
            mul_b = signed'(MUL_W'(theta_max_ff));
         end
         S_AL_MUL: begin mul_a = signed'(MUL_W'(v_ff)); mul_b = MUL_W'(alpha_span_ff); end
         S_M_RC:   begin mul_a = MUL_W'(r_s);  mul_b = ca_ff; end
         S_M_RS:   begin mul_a = MUL_W'(r_s);  mul_b = sa_ff; end
         S_M_PX:   begin mul_a = rc_ff;  mul_b = ct_ff; end
         S_M_PY:   begin mul_a = rc_ff;  mul_b = st_ff; end
         S_M_A:    begin mul_a = rs_ff;  mul_b = ct_ff; end
         S_M_B:    begin mul_a = -py_ff; mul_b = signed'(MUL_W'(theta_max_ff)); end
         S_M_C:    begin mul_a = px_ff;  mul_b = signed'(MUL_W'(theta_max_ff)); end
         S_M_D:    begin mul_a = rs_ff;  mul_b = st_ff; end
         S_M_E:    begin mul_a = -t1_ff; mul_b = MUL_W'(alpha_span_ff); end
         S_M_F:    begin mul_a = -t2_ff; mul_b = MUL_W'(alpha_span_ff); end
         S_M_G:    begin mul_a = rc_ff;  mul_b = MUL_W'(alpha_span_ff); end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
   end

   logic signed [PROD_W-1:0] prod_r30, prod_r16, prod_r2;
   logic signed [MUL_W-1:0]  rnd30;
   logic signed [31:0]       rnd16_sat;
   assign prod_r30  = (prod_ff + PROD_W'(64'sd536870912)) >>> 30;
   assign prod_r16  = (prod_ff + PROD_W'(64'sd32768)) >>> 16;
   assign prod_r2   = (prod_ff + PROD_W'(64'sd2)) >>> 2;
   assign rnd30     = prod_r30[MUL_W-1:0];
   assign rnd16_sat = sat32(prod_r16);

   // CORDIC stage, shared by rotation and vectoring
   logic signed [CX_W-1:0]  sh_x, sh_y;
   logic signed [ANG_W-1:0] atan_v;
   logic                    sigma;
   logic signed [CX_W-1:0]  cx_nx, cy_nx;
   logic signed [ANG_W-1:0] cz_nx;
   always_comb begin
      sh_x   = cx_ff >>> iter_ff;
      sh_y   = cy_ff >>> iter_ff;
      atan_v = signed'(ANG_W'(atan_q30(5'(iter_ff))));
      sigma  = (state_ff == S_ROT) ? !cz_ff[ANG_W-1] : cy_ff[CX_W-1];
      if (sigma) begin
         cx_nx = cx_ff - sh_y;
         cy_nx = cy_ff + sh_x;
         cz_nx = cz_ff - atan_v;
      end else begin
         cx_nx = cx_ff + sh_y;
         cy_nx = cy_ff - sh_x;
         cz_nx = cz_ff + atan_v;
      end
   end

   // square root step
   logic [62:0] trial;
   logic        take;
   logic [62:0] res_nx;
   logic [61:0] n_nx;
   always_comb begin
      trial = res_ff + bit_ff;
      take  = {1'b0, n_ff} >= trial;
      if (take) begin
         n_nx   = n_ff - trial[61:0];
         res_nx = (res_ff >> 1) + bit_ff;
      end else begin
         n_nx   = n_ff;
         res_nx = res_ff >> 1;
      end
   end

   logic signed [CX_W-1:0] abs_y, mag;
   assign abs_y = cy_ff[CX_W-1] ? -cy_ff : cy_ff;
   assign mag   = (cx_ff > abs_y) ? cx_ff : abs_y;

   logic signed [ANG_W-1:0] ang_half, ang_fold;
   logic                    fold_neg;
   logic signed [ANG_W-1:0] as_q16;
   always_comb begin
      ang_half = angle_ff - PI_Q30;
      fold_neg = 1'b0;
      ang_fold = ang_half;
      if (ang_half > HALF_PI_Q30) begin
         ang_fold = ang_half - PI_Q30;
         fold_neg = 1'b1;
      end else if (ang_half < -HALF_PI_Q30) begin
         ang_fold = ang_half + PI_Q30;
         fold_neg = 1'b1;
      end
      as_q16 = (cz_ff + ANG_W'(38'sd8192)) >>> 14;
   end

   logic signed [CX_W-1:0] cx_fin, cy_fin;
   assign cx_fin = neg_ff ? -cx_ff : cx_ff;
   assign cy_fin = neg_ff ? -cy_ff : cy_ff;

   logic req_xfer, csr_xfer, rsp_free, csr_hit;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_xfer  = csr_valid && csr_ready;
   assign csr_hit   = csr_xfer && (csr_index <= CSR_Z_MAX);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff      <= S_IDLE;
         theta_max_ff  <= 19'd411775;
         radius_ff     <= 31'd65536;
         z_min_ff      <= -32'sd65536;
         z_max_ff      <= 32'sd65536;
         alpha_low_ff  <= '0;
         alpha_span_ff <= '0;
         cached_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (csr_xfer) begin
                  case (csr_index)
                     CSR_THETA_MAX: begin theta_max_ff <= csr_data[18:0]; cached_ff <= 1'b0; end
                     CSR_RADIUS:    begin radius_ff <= csr_data[30:0]; cached_ff <= 1'b0; end
                     CSR_Z_MIN:     begin z_min_ff <= signed'(csr_data); cached_ff <= 1'b0; end
                     CSR_Z_MAX:     begin z_max_ff <= signed'(csr_data); cached_ff <= 1'b0; end
                     default: ;
                  endcase
               end
               if (req_xfer) begin
                  u_ff     <= req_payload.u_coord;
                  v_ff     <= req_payload.v_coord;
                  deriv_ff <= req_payload.want_derivatives;
                  side_ff  <= 1'b0;
                  state_ff <= (cached_ff && !csr_hit) ? S_TH_MUL : S_AS_RR;
               end
            end
            S_AS_RR: state_ff <= S_AS_ZZ;
            S_AS_ZZ: begin
               sq_ff    <= prod_ff[61:0];
               state_ff <= S_AS_SUB;
            end
            S_AS_SUB: begin
               n_ff     <= sq_ff - prod_ff[61:0];
               res_ff   <= '0;
               bit_ff   <= 63'd1 << 62;
               state_ff <= S_AS_SQRT;
            end
            S_AS_SQRT: begin
               n_ff   <= n_nx;
               res_ff <= res_nx;
               bit_ff <= bit_ff >> 2;
               if (bit_ff == 63'd1) begin
                  cx_ff    <= signed'(CX_W'(res_nx));
                  cy_ff    <= CX_W'(zc);
                  cz_ff    <= '0;
                  iter_ff  <= '0;
                  state_ff <= S_AS_NORM;
               end
            end
            S_AS_NORM: begin
               if (mag == '0 || mag[CX_W-1:46] != '0) begin
                  state_ff <= S_AS_COR;
               end else if (mag[CX_W-1:38] == '0) begin
                  cx_ff <= cx_ff <<< 8;
                  cy_ff <= cy_ff <<< 8;
               end else begin
                  cx_ff <= cx_ff <<< 1;
                  cy_ff <= cy_ff <<< 1;
               end
            end
            S_AS_COR: begin
               cx_ff   <= cx_nx;
               cy_ff   <= cy_nx;
               cz_ff   <= cz_nx;
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == LAST_STEP) begin
                  state_ff <= S_AS_DONE;
               end
            end
            S_AS_DONE: begin
               if (!side_ff) begin
                  alpha_low_ff <= as_q16[19:0];
                  side_ff      <= 1'b1;
                  state_ff     <= S_AS_RR;
               end else begin
                  alpha_span_ff <= as_q16[19:0] - alpha_low_ff;
                  cached_ff     <= 1'b1;
                  state_ff      <= S_TH_MUL;
               end
            end
            S_TH_MUL: state_ff <= S_TH_RND;
            S_TH_RND: begin
               angle_ff <= prod_r2[ANG_W-1:0] + PI_Q30;
               pass_ff  <= 1'b0;
               state_ff <= S_WRAP;
            end
            S_AL_MUL: state_ff <= S_AL_RND;
            S_AL_RND: begin
               angle_ff <= (ANG_W'(alpha_low_ff) <<< 14) + prod_r2[ANG_W-1:0] + PI_Q30;
               pass_ff  <= 1'b1;
               state_ff <= S_WRAP;
            end
            S_WRAP: begin
               if (angle_ff >= TWO_PI_Q30) begin
                  angle_ff <= angle_ff - TWO_PI_Q30;
               end else if (angle_ff < 0) begin
                  angle_ff <= angle_ff + TWO_PI_Q30;
               end else begin
                  cx_ff    <= GAIN_Q30;
                  cy_ff    <= '0;
                  cz_ff    <= ang_fold;
                  neg_ff   <= fold_neg;
                  iter_ff  <= '0;
                  state_ff <= S_ROT;
               end
            end
            S_ROT: begin
               cx_ff   <= cx_nx;
               cy_ff   <= cy_nx;
               cz_ff   <= cz_nx;
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == LAST_STEP) begin
                  state_ff <= S_ROT_DONE;
               end
            end
            S_ROT_DONE: begin
               if (!pass_ff) begin
                  ct_ff    <= cx_fin[MUL_W-1:0];
                  st_ff    <= cy_fin[MUL_W-1:0];
                  state_ff <= S_AL_MUL;
               end else begin
                  ca_ff    <= cx_fin[MUL_W-1:0];
                  sa_ff    <= cy_fin[MUL_W-1:0];
                  state_ff <= S_M_RC;
               end
            end
            S_M_RC: state_ff <= S_M_RS;
            S_M_RS: begin rc_ff  <= rnd30;     state_ff <= S_M_PX; end
            S_M_PX: begin rs_ff  <= rnd30;     state_ff <= S_M_PY; end
            S_M_PY: begin px_ff  <= rnd30;     state_ff <= S_M_A;  end
            S_M_A:  begin py_ff  <= rnd30;     state_ff <= S_M_B;  end
            S_M_B:  begin t1_ff  <= rnd30;     state_ff <= S_M_C;  end
            S_M_C:  begin dux_ff <= rnd16_sat; state_ff <= S_M_D;  end
            S_M_D:  begin duy_ff <= rnd16_sat; state_ff <= S_M_E;  end
            S_M_E:  begin t2_ff  <= rnd30;     state_ff <= S_M_F;  end
            S_M_F:  begin dvx_ff <= rnd16_sat; state_ff <= S_M_G;  end
            S_M_G:  begin dvy_ff <= rnd16_sat; state_ff <= S_M_H;  end
            S_M_H:  begin dvz_ff <= rnd16_sat; state_ff <= S_OUT;  end
            S_OUT: begin
               if (rsp_free) begin
                  rsp_ff.point_x <= sat32(PROD_W'(px_ff));
                  rsp_ff.point_y <= sat32(PROD_W'(py_ff));
                  rsp_ff.point_z <= sat32(PROD_W'(rs_ff));
                  rsp_ff.dpdu_x  <= deriv_ff ? dux_ff : '0;
                  rsp_ff.dpdu_y  <= deriv_ff ? duy_ff : '0;
                  rsp_ff.dpdu_z  <= '0;
                  rsp_ff.dpdv_x  <= deriv_ff ? dvx_ff : '0;
                  rsp_ff.dpdv_y  <= deriv_ff ? dvy_ff : '0;
                  rsp_ff.dpdv_z  <= deriv_ff ? dvz_ff : '0;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_cache_before_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TH_MUL) |-> cached_ff)
      else $error("angle evaluation started with stale cache");

   a_write_clears_cache: assert property (@(posedge clock) disable iff (reset)
      (csr_xfer && (csr_index == CSR_THETA_MAX || csr_index == CSR_RADIUS ||
                    csr_index == CSR_Z_MIN || csr_index == CSR_Z_MAX)) |=> !cached_ff)
      else $error("register write left cache valid");

   a_norm_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AS_COR && iter_ff == '0) |-> (mag == '0 || mag[CX_W-1:46] != '0))
      else $error("vectoring started on unnormalized operands");

   a_busy_no_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rsp_free) |=> (state_ff == S_OUT))
      else $error("result dropped while output held");

endmodule
`default_nettype wire

### test/sphere_surface_eval_unit_tb.sv
`timescale 1ns / 1ps
module sphere_surface_eval_unit_tb;
   import sse_pkg::*;

   localparam int STEPS     = 18;
   localparam int IDLE_MAX  = 20000;
   localparam int DRAIN_CYC = 300;

   localparam longint PI_L      = 64'sd3373259426;
   localparam longint TWO_PI_L  = 64'sd6746518853;
   localparam longint HALF_PI_L = 64'sd1686629713;
   localparam longint GAIN_L    = 64'sd652032874;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   sphere_surface_eval_unit #(.CORDIC_STEPS(STEPS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and angle cache
   logic [18:0]        sweep_reg;
   logic [30:0]        radius_reg;
   logic signed [31:0] zlo_reg, zhi_reg;
   longint             alpha_lo, alpha_sp;
   bit                 angles_valid;

   rsp_type expected_pts[$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   int      hold_cycles = 0;
   int      stall_mode = 0;

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic longint mulq30(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint rnd16(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint isqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   function automatic void rotate(longint ang, output longint c, output longint s);
      longint r, x, y, dx, dy;
      bit neg;
      r = (ang + PI_L) % TWO_PI_L;
      x = GAIN_L;
      y = 0;
      neg = 0;
      if (r < 0) r += TWO_PI_L;
      ang = r - PI_L;
      if (ang > HALF_PI_L) begin
         ang -= PI_L;
         neg = 1;
      end else if (ang < -HALF_PI_L) begin
         ang += PI_L;
         neg = 1;
      end
      for (int i = 0; i < STEPS && i < ATAN_N; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (ang >= 0) begin
            x -= dy; y += dx; ang -= longint'(atan_q30(i[4:0]));
         end else begin
            x += dy; y -= dx; ang += longint'(atan_q30(i[4:0]));
         end
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endfunction

   function automatic longint elevation(longint z, longint r);
      longint x, y, m, ang, dx, dy;
      ang = 0;
      if (z > r) z = r;
      if (z < -r) z = -r;
      x = isqrt(longint'(r * r - z * z));
      y = z;
      m = (y < 0) ? -y : y;
      if (x > m) m = x;
      while (m != 0 && m < (64'sd1 <<< 46)) begin
         x *= 2; y *= 2; m *= 2;
      end
      for (int i = 0; i < STEPS && i < ATAN_N; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x += dy; y -= dx; ang += longint'(atan_q30(i[4:0]));
         end else begin
            x -= dy; y += dx; ang -= longint'(atan_q30(i[4:0]));
         end
      end
      return longint'(int'((ang + (64'sd1 <<< 13)) >>> 14));
   endfunction

   function automatic rsp_type eval_surface(req_type rq);
      rsp_type o;
      longint u, v, r, th, al, ct, st, ca, sa, rc, rs, px, py, tm;
      longint lo, hi;
      u = longint'(rq.u_coord);
      v = longint'(rq.v_coord);
      r = longint'(radius_reg);
      if (!angles_valid) begin
         lo = elevation(longint'(zlo_reg), r);
         hi = elevation(longint'(zhi_reg), r);
         alpha_lo = lo;
         alpha_sp = longint'(int'(hi - lo));
         angles_valid = 1;
      end
      th = (u * longint'(sweep_reg) + 2) >>> 2;
      al = alpha_lo * 16384 + ((v * alpha_sp + 2) >>> 2);
      rotate(th, ct, st);
      rotate(al, ca, sa);
      rc = mulq30(r, ca);
      rs = mulq30(r, sa);
      px = mulq30(rc, ct);
      py = mulq30(rc, st);
      o = '0;
      o.point_x = sat32(px);
      o.point_y = sat32(py);
      o.point_z = sat32(rs);
      if (rq.want_derivatives) begin
         tm = longint'(sweep_reg);
         o.dpdu_x = sat32(rnd16(-py * tm));
         o.dpdu_y = sat32(rnd16(px * tm));
         o.dpdv_x = sat32(rnd16(-mulq30(rs, ct) * alpha_sp));
         o.dpdv_y = sat32(rnd16(-mulq30(rs, st) * alpha_sp));
         o.dpdv_z = sat32(rnd16(rc * alpha_sp));
      end
      return o;
   endfunction

   task automatic report_bad(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %h actual %h at %0t", what, want, got, $time);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid && !req_stall)
         expected_pts.push_back(eval_surface(req_payload));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pts.size() == 0) begin
            report_bad("unexpected transfer", '0, rsp_payload.point_x);
         end else begin
            want = expected_pts.pop_front();
            if (want.point_x !== rsp_payload.point_x)
               report_bad("point_x", want.point_x, rsp_payload.point_x);
            if (want.point_y !== rsp_payload.point_y)
               report_bad("point_y", want.point_y, rsp_payload.point_y);
            if (want.point_z !== rsp_payload.point_z)
               report_bad("point_z", want.point_z, rsp_payload.point_z);
            if (want.dpdu_x !== rsp_payload.dpdu_x)
               report_bad("dpdu_x", want.dpdu_x, rsp_payload.dpdu_x);
            if (want.dpdu_y !== rsp_payload.dpdu_y)
               report_bad("dpdu_y", want.dpdu_y, rsp_payload.dpdu_y);
            if (want.dpdu_z !== rsp_payload.dpdu_z)
               report_bad("dpdu_z", want.dpdu_z, rsp_payload.dpdu_z);
            if (want.dpdv_x !== rsp_payload.dpdv_x)
               report_bad("dpdv_x", want.dpdv_x, rsp_payload.dpdv_x);
            if (want.dpdv_y !== rsp_payload.dpdv_y)
               report_bad("dpdv_y", want.dpdv_y, rsp_payload.dpdv_y);
            if (want.dpdv_z !== rsp_payload.dpdv_z)
               report_bad("dpdv_z", want.dpdv_z, rsp_payload.dpdv_z);
         end
      end
   end

   // watchdog: cycles without any transfer while work is outstanding
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset || expected_pts.size() == 0 && !req_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stall pattern, with a long hold when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            default: rsp_stall <= ($urandom_range(0, 99) < 75);
         endcase
      end
   end

   task automatic send_item(logic [16:0] u, logic [16:0] v, logic d);
      req_payload <= '{u_coord: u, v_coord: v, want_derivatives: d};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic pause_sender(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_THETA_MAX: sweep_reg = val[18:0];
         CSR_RADIUS:    radius_reg = val[30:0];
         CSR_Z_MIN:     zlo_reg = val;
         CSR_Z_MAX:     zhi_reg = val;
         default: ;
      endcase
      if (idx <= CSR_Z_MAX) angles_valid = 0;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      if (req_valid) pause_sender(1);
      while (expected_pts.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_shape(logic [31:0] sw, logic [31:0] r, logic [31:0] lo, logic [31:0] hi);
      wait_idle();
      write_reg(CSR_THETA_MAX, sw);
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_Z_MIN, lo);
      write_reg(CSR_Z_MAX, hi);
   endtask

   function automatic logic [16:0] rand_param();
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return 17'd0;
      if (k == 1) return 17'd65536;
      if (k < 4) return 17'($urandom_range(65537, 131071));
      return 17'($urandom_range(0, 65536));
   endfunction

   task automatic send_burst_mix(int n);
      int left, len;
      left = n;
      while (left > 0) begin
         len = $urandom_range(1, 12);
         if (len > left) len = left;
         repeat (len) send_item(rand_param(), rand_param(), 1'($urandom_range(0, 3) != 0));
         left -= len;
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
      end
   endtask

   task automatic test_field_extremes();
      send_item(17'd0, 17'd0, 1'b1);
      send_item(17'd65536, 17'd65536, 1'b1);
      send_item(17'd131071, 17'd131071, 1'b1);
      send_item(17'd32768, 17'd32768, 1'b0);
      send_item(17'd65535, 17'd1, 1'b1);
      send_item(17'h15555, 17'h0aaaa, 1'b0);
      send_item(17'h0aaaa, 17'h15555, 1'b1);
   endtask

   task automatic test_sweep_settings();
      set_shape(32'd0, 32'd65536, -32'sd65536, 32'sd65536);
      send_item(17'd40000, 17'd20000, 1'b1);
      set_shape(32'hffffffff, 32'd65536, -32'sd65536, 32'sd65536);
      send_item(17'd65536, 17'd50000, 1'b1);
      send_item(17'd131071, 17'd0, 1'b1);
   endtask

   task automatic test_radius_extremes();
      set_shape(32'd411775, 32'd1, -32'sd1, 32'sd1);
      send_item(17'd30000, 17'd30000, 1'b1);
      set_shape(32'd411775, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_item(17'd10000, 17'd12345, 1'b1);
      send_item(17'd65536, 17'd65536, 1'b1);
      set_shape(32'd205887, 32'h80000000, -32'sd65536, 32'sd65536);
      send_item(17'd20000, 17'd40000, 1'b1);
   endtask

   task automatic test_z_clamp_and_reverse();
      set_shape(32'd411775, 32'd131072, -32'sd1000000, 32'sd1000000);
      send_item(17'd16384, 17'd49152, 1'b1);
      set_shape(32'd300000, 32'd131072, 32'sd100000, -32'sd50000);
      send_item(17'd16384, 17'd49152, 1'b1);
      send_item(17'd65536, 17'd131071, 1'b1);
   endtask

   task automatic test_bad_index();
      wait_idle();
      write_reg(4'd4, 32'hdeadbeef);
      write_reg(4'd15, 32'h00000000);
      send_item(17'd100, 17'd60000, 1'b1);
   endtask

   task automatic test_backpressure();
      set_shape(32'd411775, 32'd65536, -32'sd65536, 32'sd65536);
      @(negedge clock);
      hold_cycles = 400;
      repeat (25) send_item(rand_param(), rand_param(), 1'b1);
   endtask

   task automatic test_random_shapes();
      logic [31:0] r, lo, hi;
      for (int ph = 0; ph < 14; ph++) begin
         case ($urandom_range(0, 3))
            0: r = 32'($urandom_range(1, 4 * 65536));
            1: r = 32'($urandom_range(1, 64));
            2: r = $urandom();
            default: r = 32'($urandom_range(65536, 2000 * 65536));
         endcase
         lo = ($urandom_range(0, 3) == 0) ? $urandom() : -32'($urandom_range(0, r[30:0]));
         hi = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, r[30:0]));
         set_shape(($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 411775)),
                   r, lo, hi);
         send_burst_mix(110);
      end
   endtask

   initial begin
      sweep_reg = 19'd411775;
      radius_reg = 31'd65536;
      zlo_reg = -32'sd65536;
      zhi_reg = 32'sd65536;
      alpha_lo = 0;
      alpha_sp = 0;
      angles_valid = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_field_extremes();
      test_sweep_settings();
      test_radius_extremes();
      test_z_clamp_and_reverse();
      test_bad_index();
      test_backpressure();
      test_random_shapes();
      pause_sender(1);
      while (expected_pts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);
      if (mismatches == 0 && expected_pts.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
